// ===== src/lswc_pkg.sv =====
`timescale 1ns / 1ps

package lswc_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  // Outcode bits
  typedef logic [3:0] ocode_t;
  localparam ocode_t OC_LEFT   = 4'd1;
  localparam ocode_t OC_RIGHT  = 4'd2;
  localparam ocode_t OC_BOTTOM = 4'd4;
  localparam ocode_t OC_TOP    = 4'd8;

  localparam int PASS_W = 4;
  localparam logic [PASS_W-1:0] PASS_LIMIT = 4'd8;

  // Window register indexes
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_LEFT   = 2'd0;
  localparam reg_idx_t REG_BOTTOM = 2'd1;
  localparam reg_idx_t REG_RIGHT  = 2'd2;
  localparam reg_idx_t REG_TOP    = 2'd3;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CODE   = 7'b0000010,
    S_MUL    = 7'b0000100,
    S_DSTART = 7'b0001000,
    S_DWAIT  = 7'b0010000,
    S_UPD    = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

endpackage

// ===== src/lswc_divider.sv =====
`timescale 1ns / 1ps

module lswc_divider #(
  parameter int COORD_WIDTH = lswc_pkg::COORD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [2*COORD_WIDTH-1:0]   dividend,
  input  logic [COORD_WIDTH-1:0]     divisor,
  output logic                       done,
  output logic [2*COORD_WIDTH-1:0]   quotient
);
  import lswc_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int QW    = 2 * CW;
  localparam int CNT_W = $clog2(QW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]    rem_r, rem_nxt;
  logic [QW-1:0]    quo_r, quo_nxt;
  logic [CW-1:0]    div_r, div_nxt;
  logic [CW:0]      rem_sh;
  logic [CW:0]      trial;

  // One restoring step per cycle, MSB of the dividend first
  always_comb begin
    rem_sh   = {rem_r, quo_r[QW-1]};
    trial    = rem_sh - {1'b0, div_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, div_r}) begin
        rem_nxt = trial[CW-1:0];
        quo_nxt = {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[CW-1:0];
        quo_nxt = {quo_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== src/line_segment_window_clipper_core.sv =====
`timescale 1ns / 1ps

// Cohen-Sutherland line clipper. One segment is taken at a time; in_stall stays high
// until its result has been loaded into the output register, so a finished result
// may wait on out_stall while the next segment is already being clipped. Up to 8
// intersection passes are made per segment, each using the shared serial divider,
// which retires one quotient bit per cycle. Rejected segments return zero
// coordinates. Window registers are written through the cfg_ port and must only be
// changed while no segment is in flight.
module line_segment_window_clipper_core #(
  parameter int COORD_WIDTH = lswc_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  lswc_pkg::reg_idx_t            cfg_index,
  input  logic signed [COORD_WIDTH-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_end_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_accepted,
  output logic signed [COORD_WIDTH-1:0] out_clip_start_x,
  output logic signed [COORD_WIDTH-1:0] out_clip_start_y,
  output logic signed [COORD_WIDTH-1:0] out_clip_end_x,
  output logic signed [COORD_WIDTH-1:0] out_clip_end_y
);
  import lswc_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int QW = 2 * CW;
  localparam int SW = CW + 3;
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [QW-1:0] Q_LIM = {{(CW-2){1'b0}}, 1'b1, {(CW+1){1'b0}}};
  localparam logic signed [SW-1:0] S_MAX = SW'(C_MAX);
  localparam logic signed [SW-1:0] S_MIN = SW'(C_MIN);

  function automatic ocode_t outcode(
    input logic signed [CW-1:0] x,
    input logic signed [CW-1:0] y,
    input logic signed [CW-1:0] wl,
    input logic signed [CW-1:0] wb,
    input logic signed [CW-1:0] wr,
    input logic signed [CW-1:0] wt
  );
    ocode_t c;
    c = '0;
    if (x < wl)      c = c | OC_LEFT;
    else if (x > wr) c = c | OC_RIGHT;
    if (y < wb)      c = c | OC_BOTTOM;
    else if (y > wt) c = c | OC_TOP;
    return c;
  endfunction

  function automatic logic [CW-1:0] magn(input logic signed [CW:0] v);
    logic [CW:0] m;
    m = v[CW] ? -v : v;
    return m[CW-1:0];
  endfunction

  // window registers
  logic signed [CW-1:0] win_left_r, win_bottom_r, win_right_r, win_top_r;

  state_t state_r, state_nxt;

  logic signed [CW-1:0] x1_r, y1_r, x2_r, y2_r;
  logic [PASS_W-1:0]    pass_r;
  logic                 acc_r;

  // per-pass operands
  logic signed [CW-1:0] base_r, fixed_r;
  logic [CW-1:0]        mspan_r, mnum_r, mden_r;
  logic                 neg_r, dzero_r, move1_r, ybound_r;
  logic [QW-1:0]        prod_r;

  // output register
  logic                 out_valid_r;
  logic                 out_acc_r;
  logic signed [CW-1:0] out_sx_r, out_sy_r, out_ex_r, out_ey_r;

  ocode_t c1, c2, co;
  logic signed [CW:0] dx, dy, n_top, n_bot, n_rgt, n_lft, span, num, den;
  logic signed [CW-1:0] base_sel, fixed_sel;
  logic div_start, div_done;
  logic [QW-1:0] quo;
  logic signed [SW-1:0] q_ext, sum;
  logic signed [CW-1:0] cross_val;
  logic out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= '0;
      win_bottom_r <= '0;
      win_right_r  <= C_MAX;
      win_top_r    <= C_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEFT:   win_left_r   <= cfg_data;
        REG_BOTTOM: win_bottom_r <= cfg_data;
        REG_RIGHT:  win_right_r  <= cfg_data;
        REG_TOP:    win_top_r    <= cfg_data;
        default:    ;
      endcase
    end
  end

  // outcodes and boundary operands
  always_comb begin
    c1    = outcode(x1_r, y1_r, win_left_r, win_bottom_r, win_right_r, win_top_r);
    c2    = outcode(x2_r, y2_r, win_left_r, win_bottom_r, win_right_r, win_top_r);
    co    = (c1 != '0) ? c1 : c2;
    dx    = (CW+1)'(x2_r) - (CW+1)'(x1_r);
    dy    = (CW+1)'(y2_r) - (CW+1)'(y1_r);
    n_top = (CW+1)'(win_top_r) - (CW+1)'(y1_r);
    n_bot = (CW+1)'(win_bottom_r) - (CW+1)'(y1_r);
    n_rgt = (CW+1)'(win_right_r) - (CW+1)'(x1_r);
    n_lft = (CW+1)'(win_left_r) - (CW+1)'(x1_r);
    if ((co & OC_TOP) != '0) begin
      span = dx; num = n_top; den = dy; base_sel = x1_r; fixed_sel = win_top_r;
    end else if ((co & OC_BOTTOM) != '0) begin
      span = dx; num = n_bot; den = dy; base_sel = x1_r; fixed_sel = win_bottom_r;
    end else if ((co & OC_RIGHT) != '0) begin
      span = dy; num = n_rgt; den = dx; base_sel = y1_r; fixed_sel = win_right_r;
    end else begin
      span = dy; num = n_lft; den = dx; base_sel = y1_r; fixed_sel = win_left_r;
    end
  end

  lswc_divider #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (mden_r),
    .done     (div_done),
    .quotient (quo)
  );

  assign div_start = (state_r == S_DSTART);

  // intersection: base +/- quotient, saturated
  always_comb begin
    q_ext = SW'({1'b0, quo[CW+1:0]});
    sum   = neg_r ? (SW'(base_r) - q_ext) : (SW'(base_r) + q_ext);
    if (dzero_r) begin
      cross_val = base_r;
    end else if (quo > Q_LIM) begin
      cross_val = neg_r ? C_MIN : C_MAX;
    end else if (sum > S_MAX) begin
      cross_val = C_MAX;
    end else if (sum < S_MIN) begin
      cross_val = C_MIN;
    end else begin
      cross_val = sum[CW-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_CODE;
      S_CODE: begin
        if ((c1 == '0 && c2 == '0) || ((c1 & c2) != '0) || (pass_r >= PASS_LIMIT)) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:    state_nxt = S_DSTART;
      S_DSTART: state_nxt = S_DWAIT;
      S_DWAIT:  if (div_done) state_nxt = S_UPD;
      S_UPD:    state_nxt = S_CODE;
      S_FIN:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pass_r      <= '0;
      acc_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_IDLE) begin
        pass_r <= '0;
      end else if (state_r == S_MUL) begin
        pass_r <= pass_r + 1'b1;
      end
      if (state_r == S_CODE) begin
        acc_r <= (c1 == '0) && (c2 == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x1_r <= in_start_x;
          y1_r <= in_start_y;
          x2_r <= in_end_x;
          y2_r <= in_end_y;
        end
      end
      S_CODE: begin
        base_r   <= base_sel;
        fixed_r  <= fixed_sel;
        mspan_r  <= magn(span);
        mnum_r   <= magn(num);
        mden_r   <= magn(den);
        neg_r    <= span[CW] ^ num[CW] ^ den[CW];
        dzero_r  <= (den == '0);
        move1_r  <= (c1 != '0);
        ybound_r <= ((co & (OC_TOP | OC_BOTTOM)) != '0);
      end
      S_MUL: begin
        prod_r <= QW'(mspan_r) * QW'(mnum_r);
      end
      S_UPD: begin
        // move the outside endpoint onto the boundary
        if (move1_r) begin
          x1_r <= ybound_r ? cross_val : fixed_r;
          y1_r <= ybound_r ? fixed_r : cross_val;
        end else begin
          x2_r <= ybound_r ? cross_val : fixed_r;
          y2_r <= ybound_r ? fixed_r : cross_val;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_acc_r <= acc_r;
          out_sx_r  <= acc_r ? x1_r : '0;
          out_sy_r  <= acc_r ? y1_r : '0;
          out_ex_r  <= acc_r ? x2_r : '0;
          out_ey_r  <= acc_r ? y2_r : '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_acc_r;
  assign out_clip_start_x = out_sx_r;
  assign out_clip_start_y = out_sy_r;
  assign out_clip_end_x   = out_ex_r;
  assign out_clip_end_y   = out_ey_r;

endmodule
